[design/lru_block_buffer_cache_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the buffer cache checks
// Each macro expands to one clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH
`define LRU_BLOCK_BUFFER_CACHE_ASSERT_SVH

// same-cycle implication
`define LBBC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lbbc: assertion failed");

// next-cycle implication
`define LBBC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lbbc: assertion failed");

`endif

[design/lbbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbbc_pkg
// Types, constants and helpers shared by the buffer cache modules.
// ----------------------------------------------------------------------------
package lbbc_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam logic [IDX_W:0] ENTRIES_N = ENTRIES[IDX_W:0];

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    // operation codes
    localparam logic [1:0] OP_GET     = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOFREE = 2'd1;
    localparam logic [1:0] STAT_UNDER  = 2'd2;
    localparam logic [1:0] STAT_OVER   = 2'd3;

    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic [31:0] rtime;
        logic        cvalid;
    } entry_t;

    typedef struct packed {
        logic match;
        logic take_free;
    } cmp_t;

    function automatic logic [4:0] to_entry_out(input logic [IDX_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[4:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_to_addr(input logic [4:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[IDX_W-1:0];
    endfunction

    function automatic logic idx_in_range(input logic [4:0] idx);
        return 32'(idx) < 32'(ENTRIES);
    endfunction

endpackage

[design/lbbc_table.sv]
// ----------------------------------------------------------------------------
// lbbc_table
// Entry store: one write port, one registered read port. Entries not yet
// written read as all zero through a valid bit per entry.
// ----------------------------------------------------------------------------
module lbbc_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [lbbc_pkg::IDX_W-1:0]    rd_addr,
    output lbbc_pkg::entry_t              rd_data,
    input  logic                          wr_en,
    input  logic [lbbc_pkg::IDX_W-1:0]    wr_addr,
    input  lbbc_pkg::entry_t              wr_data
);
    import lbbc_pkg::*;

    entry_t               mem [ENTRIES];
    logic [ENTRIES-1:0]   valid_reg;
    entry_t               mem_q_reg;
    logic                 vq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
            vq_reg    <= valid_reg[rd_addr];
        end
    end

    assign rd_data = vq_reg ? mem_q_reg : '0;

endmodule

[design/lbbc_cmp.sv]
// ----------------------------------------------------------------------------
// lbbc_cmp
// Shared compare unit: tag match and oldest-free test for one entry.
// ----------------------------------------------------------------------------
module lbbc_cmp (
    input  lbbc_pkg::entry_t  ent,
    input  logic [7:0]        dev,
    input  logic [31:0]       blk,
    input  logic              free_found,
    input  logic [31:0]       best_time,
    output lbbc_pkg::cmp_t    res
);
    import lbbc_pkg::*;

    always_comb begin
        res.match     = (ent.dev == dev) && (ent.blk == blk);
        // strict compare keeps the lowest index on a tie
        res.take_free = (ent.cnt == 8'd0) && (!free_found || (ent.rtime < best_time));
    end

endmodule

[design/lru_block_buffer_cache.sv]
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// Buffer cache with reference counts and least-recently-released victim
// choice. A sequencer walks the entry store through one compare unit.
//
//   channel | direction | bits                                  | handshake
//   s_      | in        | tuser: func; tdata: dev, block_number,| tvalid/tready
//           |           |   entry_index, now_tick               |
//   m_      | out       | tdata: entry_out, hit, needs_fill,    | tvalid/tready
//           |           |   status                              |
//
// Get: the result waits on a walk over the entry store, one read per cycle
// on its single port. Release, pin, unpin: one read, then one write.
// s_tready rises together with m_tvalid when the result is loaded.
// Reset clears control state and the entry valid bits; no clearing pass.
// A result waiting on m_tready stalls the next item only at its final step.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // dev[7:0], block_number[39:8], entry_index[44:40], now_tick[76:45]
    input  logic [lbbc_pkg::S_TDATA_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [lbbc_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // entry_out[4:0], hit[5], needs_fill[6], status[8:7]
    output logic [lbbc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import lbbc_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;
    localparam logic [1:0] S_UPD   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [7:0]           dev_reg, dev_next;
    logic [31:0]          blk_reg, blk_next;
    logic [4:0]           idx_reg, idx_next;
    logic [31:0]          now_reg, now_next;
    logic                 inr_reg, inr_next;
    logic [IDX_W:0]       issue_cnt_reg, issue_cnt_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 match_found_reg, match_found_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [31:0]          best_time_reg, best_time_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 tbl_rd_en;
    logic [IDX_W-1:0]     tbl_rd_addr;
    entry_t               tbl_rd_data;
    logic                 tbl_wr_en;
    entry_t               tbl_wr_data;
    cmp_t                 cmp;

    logic                 issuing;
    logic                 res_free;
    entry_t               ent;
    logic [4:0]           r_entry;
    logic                 r_hit;
    logic                 r_fill;
    logic [1:0]           r_stat;

    lbbc_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (addr_reg),
        .wr_data (tbl_wr_data)
    );

    lbbc_cmp u_cmp (
        .ent        (tbl_rd_data),
        .dev        (dev_reg),
        .blk        (blk_reg),
        .free_found (free_found_reg),
        .best_time  (best_time_reg),
        .res        (cmp)
    );

    assign issuing  = issue_cnt_reg < ENTRIES_N;
    assign res_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        dev_next         = dev_reg;
        blk_next         = blk_reg;
        idx_next         = idx_reg;
        now_next         = now_reg;
        inr_next         = inr_reg;
        issue_cnt_next   = issue_cnt_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        best_idx_next    = best_idx_reg;
        best_time_next   = best_time_reg;
        addr_next        = addr_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        tbl_rd_en        = 1'b0;
        tbl_rd_addr      = addr_reg;
        tbl_wr_en        = 1'b0;
        ent              = tbl_rd_data;
        r_entry          = idx_reg;
        r_hit            = 1'b0;
        r_fill           = 1'b0;
        r_stat           = STAT_OK;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next          = s_tuser[1:0];
                    dev_next         = s_tdata[7:0];
                    blk_next         = s_tdata[39:8];
                    idx_next         = s_tdata[44:40];
                    now_next         = s_tdata[76:45];
                    inr_next         = idx_in_range(s_tdata[44:40]);
                    addr_next        = idx_to_addr(s_tdata[44:40]);
                    issue_cnt_next   = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    state_next       = (s_tuser[1:0] == OP_GET) ? S_SCAN : S_FETCH;
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    tbl_rd_en      = 1'b1;
                    tbl_rd_addr    = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_idx_next  = issue_cnt_reg[IDX_W-1:0];
                end
                if (pend_reg) begin
                    if (cmp.match && !match_found_reg) begin
                        match_found_next = 1'b1;
                        match_idx_next   = pend_idx_reg;
                    end
                    if (cmp.take_free) begin
                        free_found_next = 1'b1;
                        best_idx_next   = pend_idx_reg;
                        best_time_next  = tbl_rd_data.rtime;
                    end
                end
                if (!issuing && !pend_reg) begin
                    addr_next  = match_found_reg ? match_idx_reg : best_idx_reg;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                tbl_rd_en  = 1'b1;
                state_next = S_UPD;
            end
            S_UPD: begin
                if (op_reg == OP_GET) begin
                    r_entry = to_entry_out(addr_reg);
                    if (match_found_reg) begin
                        r_hit  = 1'b1;
                        r_fill = !ent.cvalid;
                        if (ent.cnt == COUNT_MAX) begin
                            r_stat = STAT_OVER;
                        end else begin
                            ent.cnt = ent.cnt + 8'd1;
                        end
                        ent.cvalid = 1'b1;
                        tbl_wr_en  = 1'b1;
                    end else if (free_found_reg) begin
                        r_fill     = 1'b1;
                        ent.dev    = dev_reg;
                        ent.blk    = blk_reg;
                        ent.cnt    = 8'd1;
                        ent.cvalid = 1'b1;
                        tbl_wr_en  = 1'b1;
                    end else begin
                        r_entry = '0;
                        r_stat  = STAT_NOFREE;
                    end
                end else if (inr_reg) begin
                    tbl_wr_en = 1'b1;
                    if (op_reg == OP_PIN) begin
                        if (ent.cnt == COUNT_MAX) begin
                            r_stat = STAT_OVER;
                        end else begin
                            ent.cnt = ent.cnt + 8'd1;
                        end
                    end else if (ent.cnt == 8'd0) begin
                        r_stat = STAT_UNDER;
                    end else begin
                        ent.cnt = ent.cnt - 8'd1;
                        if (op_reg == OP_RELEASE && ent.cnt == 8'd0) begin
                            ent.rtime = now_reg;
                        end
                    end
                end
                // hold the final step until the output register is free
                if (!res_free) begin
                    tbl_wr_en = 1'b0;
                end else begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, r_stat, r_fill, r_hit, r_entry};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        tbl_wr_data = ent;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            issue_cnt_reg <= '0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            issue_cnt_reg <= issue_cnt_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        dev_reg         <= dev_next;
        blk_reg         <= blk_next;
        idx_reg         <= idx_next;
        now_reg         <= now_next;
        inr_reg         <= inr_next;
        pend_idx_reg    <= pend_idx_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        best_idx_reg    <= best_idx_next;
        best_time_reg   <= best_time_next;
        addr_reg        <= addr_next;
        m_tdata_reg     <= m_tdata_next;
    end

endmodule

[design/lbbc_checker.sv]
// ----------------------------------------------------------------------------
// lbbc_checker
// Port-level checks on the buffer cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_block_buffer_cache_assert.svh"

module lbbc_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [lbbc_pkg::M_TDATA_W-1:0]    m_tdata
);
    import lbbc_pkg::*;

    // a pending result word stays up until taken
    `LBBC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // one item at a time: no accept right after an accept
    `LBBC_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // no free buffer gives an all-zero entry, hit and fill
    `LBBC_ASSERT_IMP(a_nofree_zero, m_tvalid && (m_tdata[8:7] == STAT_NOFREE),
                     m_tdata[6:0] == 7'd0)

    // a hit is only ever ok or saturated
    `LBBC_ASSERT_IMP(a_hit_status, m_tvalid && m_tdata[5],
                     (m_tdata[8:7] == STAT_OK) || (m_tdata[8:7] == STAT_OVER))

endmodule

bind lru_block_buffer_cache lbbc_checker u_lbbc_checker (.*);

[dv/lbbc_reply_checker.sv]
// ----------------------------------------------------------------------------
// lbbc_reply_checker
// Watches both channels of the buffer cache. Each accepted request word goes
// through a private copy of the entry table to predict its reply. Each
// accepted reply word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lbbc_reply_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // dev[7:0], block_number[39:8], entry_index[44:40], now_tick[76:45]
    input  logic [lbbc_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [lbbc_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // entry_out[4:0], hit[5], needs_fill[6], status[8:7]
    input  logic [lbbc_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             pending,
    output int                             faults
);
    import lbbc_pkg::*;

    // laid out like m_tdata, entry in the low bits
    typedef struct packed {
        logic [1:0] status;
        logic       fill;
        logic       hit;
        logic [4:0] entry;
    } cache_reply_t;

    logic [7:0]  slot_dev    [ENTRIES];
    logic [31:0] slot_blk    [ENTRIES];
    logic [7:0]  slot_cnt    [ENTRIES];
    logic [31:0] slot_stamp  [ENTRIES];
    logic        slot_filled [ENTRIES];

    cache_reply_t replies_due [$];

    initial begin
        pending = 0;
        faults  = 0;
    end

    function automatic string show(input cache_reply_t r);
        return $sformatf("entry=%0d hit=%0b fill=%0b status=%0d",
                         r.entry, r.hit, r.fill, r.status);
    endfunction

    function automatic cache_reply_t serve_request(input logic [1:0]  op,
                                                   input logic [7:0]  dev,
                                                   input logic [31:0] blk,
                                                   input logic [4:0]  idx,
                                                   input logic [31:0] tick);
        cache_reply_t r;
        int           pick;
        bit           found;
        r.entry  = idx;
        r.hit    = 1'b0;
        r.fill   = 1'b0;
        r.status = STAT_OK;
        pick     = 0;
        found    = 1'b0;
        if (op == OP_GET) begin
            r.entry = '0;
            // lowest matching tag wins
            for (int i = 0; i < ENTRIES; i++) begin
                if (!found && slot_dev[i] == dev && slot_blk[i] == blk) begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            if (found) begin
                if (slot_cnt[pick] >= COUNT_MAX)
                    r.status = STAT_OVER;
                else
                    slot_cnt[pick] = slot_cnt[pick] + 8'd1;
                r.entry = 5'(pick);
                r.hit   = 1'b1;
                r.fill  = !slot_filled[pick];
                slot_filled[pick] = 1'b1;
            end else begin
                // oldest release among free entries, strict compare keeps
                // the lowest index
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_cnt[i] == 8'd0 &&
                        (!found || slot_stamp[i] < slot_stamp[pick])) begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    r.status = STAT_NOFREE;
                end else begin
                    slot_dev[pick]    = dev;
                    slot_blk[pick]    = blk;
                    slot_cnt[pick]    = 8'd1;
                    slot_filled[pick] = 1'b1;
                    r.entry = 5'(pick);
                    r.fill  = 1'b1;
                end
            end
        end else if (int'(idx) < ENTRIES) begin
            pick = int'(idx);
            if (op == OP_PIN) begin
                if (slot_cnt[pick] >= COUNT_MAX)
                    r.status = STAT_OVER;
                else
                    slot_cnt[pick] = slot_cnt[pick] + 8'd1;
            end else if (slot_cnt[pick] == 8'd0) begin
                r.status = STAT_UNDER;
            end else begin
                slot_cnt[pick] = slot_cnt[pick] - 8'd1;
                if (op == OP_RELEASE && slot_cnt[pick] == 8'd0)
                    slot_stamp[pick] = tick;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        cache_reply_t want;
        cache_reply_t got;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_dev[i]    = '0;
                slot_blk[i]    = '0;
                slot_cnt[i]    = '0;
                slot_stamp[i]  = '0;
                slot_filled[i] = 1'b0;
            end
            replies_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                replies_due.push_back(serve_request(s_tuser[1:0], s_tdata[7:0],
                                                    s_tdata[39:8], s_tdata[44:40],
                                                    s_tdata[76:45]));
            if (m_tvalid && m_tready) begin
                got = cache_reply_t'(m_tdata[8:0]);
                if (replies_due.size() == 0) begin
                    if (faults < 10)
                        $display("lbbc: reply word with nothing pending: %s", show(got));
                    faults = faults + 1;
                end else begin
                    want = replies_due.pop_front();
                    if (got.entry !== want.entry || got.hit !== want.hit ||
                        got.fill !== want.fill || got.status !== want.status) begin
                        if (faults < 10)
                            $display("lbbc: reply mismatch: expected %s, got %s",
                                     show(want), show(got));
                        faults = faults + 1;
                    end
                end
            end
        end
        pending = replies_due.size();
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives request words into the buffer cache: a short directed run over tag
// hits, fills, victim choice, underflow and count saturation, then random
// working-set, fill-and-drain and noise sequences with random idling on both
// channels. Replies are checked by lbbc_reply_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import lbbc_pkg::*;

    localparam int RANDOM_ITEMS = 260;
    localparam int QUIET_ITEMS  = 100;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 500000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int          pending;
    int          faults;
    int          sent      = 0;
    int          gap_pct   = 20;
    int          stall_pct = 20;
    bit          hold_ask  = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned cycle_cnt = 0;

    always #1 aclk = ~aclk;

    lru_block_buffer_cache u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lbbc_reply_checker u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .pending  (pending),
        .faults   (faults)
    );

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_word(input logic [1:0]  op,
                             input logic [7:0]  dev,
                             input logic [31:0] blk,
                             input logic [4:0]  idx,
                             input logic [31:0] tick);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, tick, idx, blk, dev};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent = sent + 1;
    endtask

    // hold the source until every reply has come back
    task automatic pause_drain();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
    endtask

    // result sink: random short stalls, one long hold when asked
    initial begin : sink
        int n;
        forever begin
            @(negedge aclk);
            if (hold_ask && !hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                n = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt = cycle_cnt + 1;
        end
        $display("[lru_block_buffer_cache] ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [39:0] tag_pool [8];
        logic [39:0] tg;
        logic [31:0] tick;
        int          order [32];
        int          goal;
        int          n;
        int          k;
        int          j;
        int          t;
        bit          quiet;

        tick = 32'd0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // every tag is zero after reset: lowest match is entry 0, contents not yet valid
        send_word(OP_GET, 8'h00, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF);
        send_word(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000);
        send_word(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0000_0000);
        send_word(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'h0000_0000);
        // release and unpin on a free entry report underflow; the count stays at zero
        send_word(OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'h1234_5678);
        send_word(OP_UNPIN, 8'h00, 32'h0000_0000, 5'd30, 32'h0000_0000);
        send_word(OP_PIN, 8'h00, 32'h0000_0000, 5'd31, 32'h0000_0000);
        send_word(OP_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF);
        // newest stamp on entry 2 pushes the victim past it
        send_word(OP_PIN, 8'h00, 32'h0000_0000, 5'd2, 32'h0000_0000);
        send_word(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd2, 32'hFFFF_FFFF);
        send_word(OP_GET, 8'h01, 32'h0000_0001, 5'd0, 32'h0000_0000);
        send_word(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd3, 32'h0000_0000);
        // stamp ties: lowest index wins
        send_word(OP_GET, 8'h02, 32'h0000_0002, 5'd0, 32'h0000_0000);
        send_word(OP_GET, 8'h01, 32'h0000_0001, 5'd0, 32'h0000_0000);
        send_word(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'h0000_0010);
        send_word(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd1, 32'h0000_0011);
        send_word(OP_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'h0000_0000);

        // saturate entry 0 (still tagged 0/0) while the sink holds off
        hold_ask = 1'b1;
        for (j = 0; j < 256; j++)
            send_word(OP_PIN, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000);
        send_word(OP_GET, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000);
        for (j = 0; j < 200; j++)
            send_word(OP_UNPIN, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_0000);
        for (j = 0; j < 60; j++)
            send_word(OP_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'h0000_1000 + j);
        pause_drain();

        goal = sent + RANDOM_ITEMS;
        while (sent < goal) begin
            quiet     = (goal - sent) < QUIET_ITEMS;
            gap_pct   = (quiet || $urandom_range(0, 3) == 0) ? 0 : 20;
            stall_pct = (quiet || $urandom_range(0, 3) == 0) ? 0 : 20;
            if (!quiet && $urandom_range(0, 7) == 0)
                pause_drain();
            if ($urandom_range(0, 5) == 0)
                tick = $urandom();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // small working set: frequent hits, mixed count traffic
                    n = $urandom_range(2, 8);
                    for (j = 0; j < n; j++) begin
                        tag_pool[j][39:8] = $urandom_range(0, 1) ? 32'($urandom_range(0, 7))
                                                                 : 32'($urandom());
                        tag_pool[j][7:0]  = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                                                 : 8'($urandom());
                    end
                    k = $urandom_range(15, 40);
                    for (j = 0; j < k; j++) begin
                        t    = $urandom_range(0, 9);
                        tick = tick + 32'($urandom_range(0, 1000));
                        tg   = tag_pool[$urandom_range(0, n - 1)];
                        if (t < 5)
                            send_word(OP_GET, tg[7:0], tg[39:8], 5'($urandom()), $urandom());
                        else if (t < 8)
                            send_word(OP_RELEASE, 8'($urandom()), $urandom(), 5'($urandom()), tick);
                        else if (t == 8)
                            send_word(OP_PIN, 8'($urandom()), $urandom(), 5'($urandom()), tick);
                        else
                            send_word(OP_UNPIN, 8'($urandom()), $urandom(), 5'($urandom()), tick);
                    end
                end
                5, 6, 7: begin
                    // get 28 to 38 mostly new tags, then release every entry in random order, once or twice
                    n = $urandom_range(28, 38);
                    tg = '0;
                    for (j = 0; j < n; j++) begin
                        if (j == 0 || $urandom_range(0, 4) != 0) begin
                            tg[39:8] = $urandom();
                            tg[7:0]  = 8'($urandom());
                        end
                        send_word(OP_GET, tg[7:0], tg[39:8], 5'($urandom()), $urandom());
                    end
                    for (j = 0; j < 32; j++)
                        order[j] = j;
                    for (j = 31; j > 0; j--) begin
                        t        = $urandom_range(0, j);
                        k        = order[j];
                        order[j] = order[t];
                        order[t] = k;
                    end
                    t = $urandom_range(1, 2);
                    for (k = 0; k < t; k++) begin
                        for (j = 0; j < 32; j++) begin
                            tick = tick + 32'($urandom_range(0, 3));
                            send_word(OP_RELEASE, 8'($urandom()), $urandom(),
                                      5'(order[j]), tick);
                        end
                    end
                end
                default: begin
                    k = $urandom_range(4, 12);
                    for (j = 0; j < k; j++)
                        send_word(2'($urandom()), 8'($urandom()), $urandom(),
                                  5'($urandom()), $urandom());
                end
            endcase
        end

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (faults == 0 && pending == 0)
            $display("[lru_block_buffer_cache] OK");
        else
            $display("[lru_block_buffer_cache] ERROR");
        $finish;
    end

endmodule
